/* src/ansi_escape_interpreter_unit_macros.svh */
// ----------------------------------------------------------------------------
// ansi escape interpreter assertion macros
// shared helpers for the port checker
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_INTERPRETER_UNIT_MACROS_SVH
`define ANSI_ESCAPE_INTERPRETER_UNIT_MACROS_SVH

// implication checked on every rising edge outside reset
`define AEI_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication outside reset
`define AEI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* src/aei_pkg.sv */
// ----------------------------------------------------------------------------
// aei_pkg
// shared types and constants of the escape sequence interpreter
// ----------------------------------------------------------------------------
package aei_pkg;

  localparam int unsigned ValW = 14;
  localparam logic [13:0] ParamSat = 14'd9999;

  localparam logic [7:0] EscByte    = 8'd27;
  localparam logic [7:0] SoundEnd   = 8'd14;
  localparam logic [7:0] ReverseAttr = 8'h70;
  localparam logic [7:0] LowNibble  = 8'h0F;
  localparam logic [7:0] HighNibble = 8'hF0;
  localparam logic [7:0] BlinkBit   = 8'd128;
  localparam logic [7:0] BoldBit    = 8'd8;
  localparam logic [13:0] StatusQuery = 14'd6;

  // register indexes
  localparam logic [1:0] RegScreenRows = 2'd0;
  localparam logic [1:0] RegScreenCols = 2'd1;
  localparam logic [1:0] RegScrollRows = 2'd2;
  localparam logic [1:0] RegColorMap   = 2'd3;

  // action codes
  localparam logic [3:0] ActNone    = 4'd0;
  localparam logic [3:0] ActPass    = 4'd1;
  localparam logic [3:0] ActSndOn   = 4'd2;
  localparam logic [3:0] ActSndOff  = 4'd3;
  localparam logic [3:0] ActCls     = 4'd4;
  localparam logic [3:0] ActEol     = 4'd5;
  localparam logic [3:0] ActStatus  = 4'd6;
  localparam logic [3:0] ActAttr    = 4'd7;
  localparam logic [3:0] ActSave    = 4'd8;
  localparam logic [3:0] ActRestore = 4'd9;
  localparam logic [3:0] ActUp      = 4'd10;
  localparam logic [3:0] ActDown    = 4'd11;
  localparam logic [3:0] ActLeft    = 4'd12;
  localparam logic [3:0] ActRight   = 4'd13;
  localparam logic [3:0] ActAbs     = 4'd14;
  localparam logic [3:0] ActUnknown = 4'd15;

  // controller to datapath
  typedef struct packed {
    logic       load;      // latch the input item, run the byte decode
    logic       sgr_step;  // apply one sgr parameter
    logic       finish;    // form the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       sgr_run;   // a sgr letter is pending with parameters
    logic       sgr_last;  // current sgr parameter is the last one
  } sts_t;

endpackage

/* src/aei_datapath.sv */
// ----------------------------------------------------------------------------
// aei_datapath
// parser state, parameter gathering, sgr engine and cursor arithmetic
// ----------------------------------------------------------------------------
module aei_datapath #(
  parameter int unsigned ArgBufLen = 64,
  parameter int unsigned MaxParams = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [23:0]     cfg_data_i,
  input  logic [7:0]      ch_i,
  input  logic [7:0]      cur_row_i,
  input  logic [7:0]      cur_col_i,
  input  aei_pkg::cmd_t   cmd_i,
  output aei_pkg::sts_t   sts_o,
  output logic [63:0]     res_o
);

  localparam int unsigned CntW = $clog2(MaxParams + 1);
  localparam int unsigned IdxW = (MaxParams > 1) ? $clog2(MaxParams) : 1;
  localparam int unsigned ArgW = $clog2(ArgBufLen);

  // configuration registers
  logic [7:0]  rows_q, cols_q, scroll_q;
  logic [23:0] cmap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= 8'd24;
      cols_q   <= 8'd80;
      scroll_q <= 8'd24;
      cmap_q   <= 24'd15637664;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aei_pkg::RegScreenRows: rows_q   <= cfg_data_i[7:0];
        aei_pkg::RegScreenCols: cols_q   <= cfg_data_i[7:0];
        aei_pkg::RegScrollRows: scroll_q <= cfg_data_i[7:0];
        aei_pkg::RegColorMap:   cmap_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser state
  logic            esc_open_q, esc_open_d, after_esc_q, after_esc_d;
  logic            snd_q, snd_d, in_dig_q, in_dig_d, lead_q, lead_d;
  logic            blink_q, blink_d, bold_q, bold_d;
  logic [13:0]     pv_q [MaxParams];
  logic [13:0]     pv_d [MaxParams];
  logic [CntW-1:0] pcnt_q, pcnt_d;
  logic [ArgW-1:0] argc_q, argc_d;
  logic [7:0]      attr_q, attr_d, srow_q, srow_d, scol_q, scol_d;

  // item registers
  logic [7:0]      nr_q, nc_q, nr_d, nc_d;
  logic [3:0]      act_q, act_d;
  logic [13:0]     md_q, md_d;
  logic            fs_q, fs_d, bs_q, bs_d;
  logic [2:0]      fi_q, fi_d, bi_q, bi_d;
  logic            sgr_q, sgr_d;
  logic [IdxW-1:0] si_q, si_d;
  logic [CntW-1:0] sn_q, sn_d;
  logic [63:0]     res_q, res_d;

  // byte decode helpers
  logic            alpha, is_dig;
  logic [13:0]     a0, a1, delta, code, acc, tr, tc;
  logic [17:0]     mul;
  logic [7:0]      lim, tr8, tc8;
  logic [2:0]      cidx, mapc;

  assign alpha  = (ch_i >= 8'h41 && ch_i <= 8'h5A) || (ch_i >= 8'h61 && ch_i <= 8'h7A);
  assign is_dig = ch_i >= 8'h30 && ch_i <= 8'h39;
  assign a0     = (pcnt_q > CntW'(0)) ? pv_q[0] : 14'd0;
  assign a1     = (pcnt_q > CntW'(1)) ? pv_q[1] : 14'd0;
  assign delta  = (pcnt_q > CntW'(0)) ? a0 : 14'd1;
  assign code   = pv_q[si_q];

  always_comb begin
    esc_open_d = esc_open_q; after_esc_d = after_esc_q; snd_d = snd_q;
    in_dig_d = in_dig_q; lead_d = lead_q; blink_d = blink_q; bold_d = bold_q;
    pv_d = pv_q; pcnt_d = pcnt_q; argc_d = argc_q; attr_d = attr_q;
    srow_d = srow_q; scol_d = scol_q;
    act_d = act_q; nr_d = nr_q; nc_d = nc_q; md_d = md_q;
    fs_d = fs_q; fi_d = fi_q; bs_d = bs_q; bi_d = bi_q;
    sgr_d = sgr_q; si_d = si_q; sn_d = sn_q; res_d = res_q;
    acc = 14'd0; mul = 18'd0; lim = 8'd0; tr = 14'd0; tc = 14'd0;
    tr8 = 8'd0; tc8 = 8'd0; cidx = 3'd0; mapc = 3'd0;

    if (cmd_i.load) begin
      act_d = aei_pkg::ActNone; nr_d = cur_row_i; nc_d = cur_col_i;
      md_d = 14'd0; fs_d = 1'b0; fi_d = 3'd0; bs_d = 1'b0; bi_d = 3'd0;
      sgr_d = 1'b0; si_d = '0; sn_d = pcnt_q;
      if (ch_i == aei_pkg::EscByte) begin
        for (int i = 0; i < MaxParams; i++) pv_d[i] = 14'd0;
        pcnt_d = '0; in_dig_d = 1'b0; lead_d = 1'b0; argc_d = '0;
        after_esc_d = 1'b1; esc_open_d = 1'b1;
      end else if (after_esc_q) begin
        after_esc_d = 1'b0;
        if (ch_i == 8'h5B) esc_open_d = 1'b1;
        else begin
          esc_open_d = 1'b0; act_d = aei_pkg::ActPass;
        end
      end else if (!esc_open_q && !snd_q) begin
        // ignored byte
      end else if (snd_q && ch_i == aei_pkg::SoundEnd) begin
        snd_d = 1'b0; esc_open_d = 1'b0; act_d = aei_pkg::ActSndOff;
      end else if (alpha && !snd_q) begin
        esc_open_d = 1'b0;
        case (ch_i)
          8'h4D: begin
            snd_d = 1'b1; esc_open_d = 1'b1; act_d = aei_pkg::ActSndOn;
          end
          8'h4A: begin
            act_d = aei_pkg::ActCls; nr_d = 8'd0; nc_d = 8'd0;
          end
          8'h4B: act_d = aei_pkg::ActEol;
          8'h6E: act_d = (a0 == aei_pkg::StatusQuery) ? aei_pkg::ActStatus
                                                      : aei_pkg::ActNone;
          8'h6D: begin
            act_d = aei_pkg::ActAttr; sgr_d = pcnt_q != '0;
          end
          8'h73: begin
            act_d = aei_pkg::ActSave; srow_d = cur_row_i; scol_d = cur_col_i;
          end
          8'h75: begin
            act_d = aei_pkg::ActRestore; nr_d = srow_q; nc_d = scol_q;
          end
          8'h41: begin
            act_d = aei_pkg::ActUp; md_d = delta;
            nr_d = ({6'd0, cur_row_i} > delta) ? 8'(14'(cur_row_i) - delta) : 8'd0;
          end
          8'h42: begin
            act_d = aei_pkg::ActDown; md_d = delta;
            lim = (rows_q != 8'd0) ? rows_q - 8'd1 : 8'd0;
            nr_d = (15'(cur_row_i) + 15'(delta) > 15'(lim)) ? lim
                   : 8'(14'(cur_row_i) + delta);
          end
          8'h44: begin
            act_d = aei_pkg::ActLeft; md_d = delta;
            nc_d = ({6'd0, cur_col_i} > delta) ? 8'(14'(cur_col_i) - delta) : 8'd0;
          end
          8'h43: begin
            act_d = aei_pkg::ActRight; md_d = delta;
            lim = (cols_q != 8'd0) ? cols_q - 8'd1 : 8'd0;
            nc_d = (15'(cur_col_i) + 15'(delta) > 15'(lim)) ? lim
                   : 8'(14'(cur_col_i) + delta);
          end
          8'h48, 8'h66: begin
            act_d = aei_pkg::ActAbs;
            if (pcnt_q == CntW'(1)) begin
              if (lead_q) tc = a0; else tr = a0;
            end else if (pcnt_q == CntW'(2)) begin
              tr = a0; tc = a1;
            end
            tr = (tr != 14'd0) ? tr - 14'd1 : 14'd0;
            tc = (tc != 14'd0) ? tc - 14'd1 : 14'd0;
            tr8 = (scroll_q != 8'd0) ? scroll_q - 8'd1 : 8'd0;
            tc8 = (cols_q != 8'd0) ? cols_q - 8'd1 : 8'd0;
            nr_d = (tr > 14'(tr8)) ? tr8 : tr[7:0];
            nc_d = (tc > 14'(tc8)) ? tc8 : tc[7:0];
          end
          default: act_d = aei_pkg::ActUnknown;
        endcase
      end else if (esc_open_q) begin
        // collect one byte of parameter text
        if (ch_i != 8'd0 && 32'(argc_q) < ArgBufLen - 1) begin
          if (argc_q == '0 && ch_i == 8'h3B) lead_d = 1'b1;
          argc_d = argc_q + ArgW'(1);
          if (is_dig) begin
            if (in_dig_q && pcnt_q != '0) begin
              acc = pv_q[IdxW'(pcnt_q - CntW'(1))];
              mul = 18'({acc, 3'd0}) + 18'({acc, 1'b0}) + 18'(ch_i - 8'h30);
              pv_d[IdxW'(pcnt_q - CntW'(1))] =
                (mul > 18'(aei_pkg::ParamSat)) ? aei_pkg::ParamSat : mul[13:0];
            end else if (!in_dig_q && 32'(pcnt_q) < MaxParams) begin
              pv_d[IdxW'(pcnt_q)] = 14'(ch_i - 8'h30);
              pcnt_d = pcnt_q + CntW'(1);
              in_dig_d = 1'b1;
            end
          end else begin
            in_dig_d = 1'b0;
          end
        end
      end
    end

    // one sgr parameter per cycle
    if (cmd_i.sgr_step) begin
      cidx = 3'(code);
      if (code == 14'd5) begin
        attr_d = attr_q | aei_pkg::BlinkBit; blink_d = 1'b1;
      end else if (code == 14'd4) begin
        attr_d = attr_q | 8'd1;
      end else if (code == 14'd7) begin
        attr_d = aei_pkg::ReverseAttr | (bold_q ? aei_pkg::BoldBit : 8'd0)
               | (blink_q ? aei_pkg::BlinkBit : 8'd0);
      end else if (code == 14'd0) begin
        attr_d = 8'd7; blink_d = 1'b0; bold_d = 1'b0;
      end else if (code == 14'd1) begin
        attr_d = attr_q | aei_pkg::BoldBit; bold_d = 1'b1;
      end else if (code >= 14'd40 && code <= 14'd47) begin
        mapc = cmap_q[3*cidx +: 3];
        attr_d = (attr_q & aei_pkg::LowNibble) | {1'b0, mapc, 4'd0}
               | (blink_q ? aei_pkg::BlinkBit : 8'd0);
        bs_d = 1'b1; bi_d = cidx;
      end else if (code >= 14'd30 && code <= 14'd37) begin
        cidx = 3'(code - 14'd30);
        mapc = cmap_q[3*cidx +: 3];
        attr_d = (attr_q & aei_pkg::HighNibble) | {5'd0, mapc}
               | (bold_q ? aei_pkg::BoldBit : 8'd0);
        fs_d = 1'b1; fi_d = cidx;
      end
      si_d = si_q + IdxW'(1);
      sgr_d = !(CntW'(si_q) + CntW'(1) >= sn_q);
    end

    // output word
    if (cmd_i.finish) begin
      res_d = {13'd0, (esc_open_q || after_esc_q || snd_q), md_q,
               bi_q, bs_q, fi_q, fs_q, attr_q, nc_q, nr_q, act_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_open_q <= 1'b0; after_esc_q <= 1'b0; snd_q <= 1'b0;
      in_dig_q <= 1'b0; lead_q <= 1'b0; blink_q <= 1'b0; bold_q <= 1'b0;
      for (int i = 0; i < MaxParams; i++) pv_q[i] <= 14'd0;
      pcnt_q <= '0; argc_q <= '0; attr_q <= 8'd7; srow_q <= 8'd0; scol_q <= 8'd0;
      sgr_q <= 1'b0;
    end else begin
      esc_open_q <= esc_open_d; after_esc_q <= after_esc_d; snd_q <= snd_d;
      in_dig_q <= in_dig_d; lead_q <= lead_d; blink_q <= blink_d; bold_q <= bold_d;
      pv_q <= pv_d; pcnt_q <= pcnt_d; argc_q <= argc_d; attr_q <= attr_d;
      srow_q <= srow_d; scol_q <= scol_d; sgr_q <= sgr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d; nr_q <= nr_d; nc_q <= nc_d; md_q <= md_d;
    fs_q <= fs_d; fi_q <= fi_d; bs_q <= bs_d; bi_q <= bi_d;
    si_q <= si_d; sn_q <= sn_d; res_q <= res_d;
  end

  assign sts_o.sgr_run  = sgr_q;
  assign sts_o.sgr_last = CntW'(si_q) + CntW'(1) >= sn_q;
  assign res_o = res_q;

endmodule

/* src/aei_ctrl.sv */
// ----------------------------------------------------------------------------
// aei_ctrl
// sequencer: accept, decode, sgr steps, output handshake
// ----------------------------------------------------------------------------
module aei_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output aei_pkg::cmd_t cmd_o,
  input  aei_pkg::sts_t sts_i
);

  typedef enum logic [1:0] {StIdle, StDecode, StSgr, StDone} state_e;

  state_e state_q;
  logic   mv_q;

  // accept only with the output register free or draining
  assign s_ready_o  = (state_q == StIdle) && (!mv_q || m_ready_i);
  assign m_valid_o  = mv_q;
  assign cmd_o.load     = s_valid_i && s_ready_o;
  assign cmd_o.sgr_step = (state_q == StSgr);
  assign cmd_o.finish   = (state_q == StDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mv_q    <= 1'b0;
    end else begin
      if (mv_q && m_ready_i) mv_q <= 1'b0;
      case (state_q)
        StIdle:   if (cmd_o.load) state_q <= StDecode;
        StDecode: state_q <= sts_i.sgr_run ? StSgr : StDone;
        StSgr:    if (sts_i.sgr_last) state_q <= StDone;
        StDone: begin
          mv_q    <= 1'b1;
          state_q <= StIdle;
        end
        default:  state_q <= StIdle;
      endcase
    end
  end

endmodule

/* src/ansi_escape_interpreter_unit.sv */
// flow: a byte is accepted in idle, passes decode, any sgr steps and done, which
// fills the output register; no new byte is taken until the state is idle and the
// output register free or draining; the sgr engine applies one parameter per cycle
// reset: asynchronous active low; parser idle, attribute 0x07, registers at defaults
// ----------------------------------------------------------------------------
// ansi_escape_interpreter_unit
// terminal escape sequence interpreter with cursor tracking
// ----------------------------------------------------------------------------
module ansi_escape_interpreter_unit #(
  parameter int unsigned ARG_BUF_LEN = 64,
  parameter int unsigned MAX_PARAMS  = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ch [7:0], cur_row [15:8], cur_col [23:16]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // action [3:0], new_row [11:4], new_col [19:12], text_attr [27:20],
  // fore_set [28], fore_index [31:29], back_set [32], back_index [35:33],
  // move_delta [49:36], in_escape [50], zero fill up to bit 55
  output logic [55:0] m_axis_tdata
);

  aei_pkg::cmd_t cmd;
  aei_pkg::sts_t sts;
  logic [63:0]   res;

  aei_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid), .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid), .m_ready_i (m_axis_tready),
    .cmd_o (cmd), .sts_i (sts)
  );

  aei_datapath #(.ArgBufLen(ARG_BUF_LEN), .MaxParams(MAX_PARAMS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .ch_i (s_axis_tdata[7:0]), .cur_row_i (s_axis_tdata[15:8]),
    .cur_col_i (s_axis_tdata[23:16]),
    .cmd_i (cmd), .sts_o (sts), .res_o (res)
  );

  assign m_axis_tdata = res[55:0];

endmodule

/* src/aei_checker.sv */
// ----------------------------------------------------------------------------
// aei_checker
// port level checks of the escape sequence interpreter
// ----------------------------------------------------------------------------
`include "ansi_escape_interpreter_unit_macros.svh"

module aei_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // a stalled result holds
  `AEI_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid)
  // no accept the cycle after an accept
  `AEI_ASSERT_NEXT(a_gap, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // fill bits stay zero
  `AEI_ASSERT_IMPL(a_fill, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[55:51] == 5'd0)
  // an action with a code below 8 carries no move count
  `AEI_ASSERT_IMPL(a_delta, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[3:2] != 2'b10 && m_axis_tdata[3:2] != 2'b11, m_axis_tdata[49:36] == 14'd0)

endmodule

bind ansi_escape_interpreter_unit aei_checker u_aei_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the escape sequence interpreter: a byte stream of
// control sequences with random cursor positions is pushed through the slave
// port, every output beat is checked against a behavioral tracker of the
// parser state, attribute byte and saved cursor, under random back-pressure
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ArgBufLen = 64;
  localparam int unsigned MaxParams = 5;

  typedef struct packed {
    logic [7:0] cur_col;
    logic [7:0] cur_row;
    logic [7:0] ch;
  } char_beat_t;

  typedef struct packed {
    logic [4:0]  fill;
    logic        in_escape;
    logic [13:0] move_delta;
    logic [2:0]  back_index;
    logic        back_set;
    logic [2:0]  fore_index;
    logic        fore_set;
    logic [7:0]  text_attr;
    logic [7:0]  new_col;
    logic [7:0]  new_row;
    logic [3:0]  action;
  } term_action_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  ansi_escape_interpreter_unit dut (.*);

  // tracked terminal state
  logic [7:0]  t_rows, t_cols, t_scroll;
  logic [23:0] t_cmap;
  bit          t_open, t_after_esc, t_sound, t_digits, t_lead_semi, t_blink, t_bold;
  int unsigned t_vals[MaxParams];
  int unsigned t_count, t_chars;
  logic [7:0]  t_attr, t_saved_row, t_saved_col;

  char_beat_t   char_q[$];
  term_action_t action_q[$];
  int           errors = 0;
  bit           idle_free = 0;
  bit           stim_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [2:0] map_color(int unsigned idx);
    return t_cmap[3*idx +: 3];
  endfunction

  function automatic int unsigned clamp_lim(int unsigned v, logic [7:0] n);
    int unsigned hi;
    hi = (n != 0) ? n - 1 : 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void drop_params();
    foreach (t_vals[i]) t_vals[i] = 0;
    t_count = 0;
    t_digits = 0;
    t_lead_semi = 0;
    t_chars = 0;
  endfunction

  function automatic void gather_char(logic [7:0] c);
    int unsigned v;
    if (c == 0 || t_chars >= ArgBufLen - 1) return;
    if (t_chars == 0 && c == ";") t_lead_semi = 1;
    t_chars++;
    if (c >= "0" && c <= "9") begin
      if (t_digits && t_count > 0) begin
        v = t_vals[t_count-1] * 10 + (c - "0");
        t_vals[t_count-1] = (v > aei_pkg::ParamSat) ? aei_pkg::ParamSat : v;
      end else if (!t_digits && t_count < MaxParams) begin
        t_vals[t_count] = c - "0";
        t_count++;
        t_digits = 1;
      end
    end else begin
      t_digits = 0;
    end
  endfunction

  function automatic void apply_sgr_code(int unsigned code, inout term_action_t r);
    if (code == 5) begin
      t_attr |= aei_pkg::BlinkBit;
      t_blink = 1;
    end else if (code == 4) begin
      t_attr |= 8'd1;
    end else if (code == 7) begin
      t_attr = aei_pkg::ReverseAttr | (t_bold ? aei_pkg::BoldBit : 8'd0)
               | (t_blink ? aei_pkg::BlinkBit : 8'd0);
    end else if (code == 0) begin
      t_attr = 8'd7;
      t_blink = 0;
      t_bold = 0;
    end else if (code == 1) begin
      t_attr |= aei_pkg::BoldBit;
      t_bold = 1;
    end else if (code >= 40 && code <= 47) begin
      t_attr = (t_attr & aei_pkg::LowNibble) | {1'b0, map_color(code - 40), 4'd0}
               | (t_blink ? aei_pkg::BlinkBit : 8'd0);
      r.back_set = 1;
      r.back_index = 3'(code - 40);
    end else if (code >= 30 && code <= 37) begin
      t_attr = (t_attr & aei_pkg::HighNibble) | {5'd0, map_color(code - 30)}
               | (t_bold ? aei_pkg::BoldBit : 8'd0);
      r.fore_set = 1;
      r.fore_index = 3'(code - 30);
    end
  endfunction

  // advance the tracked state by one character and return the expected action
  function automatic term_action_t interpret_char(char_beat_t b);
    term_action_t r;
    logic [7:0]  c;
    bit          alpha;
    int unsigned a0, a1, delta, tr, tc;
    r = '0;
    c = b.ch;
    r.new_row = b.cur_row;
    r.new_col = b.cur_col;
    r.action = aei_pkg::ActNone;
    alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    if (c == aei_pkg::EscByte) begin
      drop_params();
      t_after_esc = 1;
      t_open = 1;
    end else if (t_after_esc) begin
      t_after_esc = 0;
      if (c == "[") t_open = 1;
      else begin
        t_open = 0;
        r.action = aei_pkg::ActPass;
      end
    end else if (!t_open && !t_sound) begin
      // stray byte, nothing happens
    end else if (t_sound && c == aei_pkg::SoundEnd) begin
      t_sound = 0;
      t_open = 0;
      r.action = aei_pkg::ActSndOff;
    end else if (alpha && !t_sound) begin
      a0 = (t_count > 0) ? t_vals[0] : 0;
      a1 = (t_count > 1) ? t_vals[1] : 0;
      delta = (t_count > 0) ? a0 : 1;
      t_open = 0;
      case (c)
        "M": begin
          t_sound = 1;
          t_open = 1;
          r.action = aei_pkg::ActSndOn;
        end
        "J": begin
          r.action = aei_pkg::ActCls;
          r.new_row = 0;
          r.new_col = 0;
        end
        "K": r.action = aei_pkg::ActEol;
        "n": r.action = (a0 == aei_pkg::StatusQuery) ? aei_pkg::ActStatus
                                                     : aei_pkg::ActNone;
        "m": begin
          r.action = aei_pkg::ActAttr;
          for (int i = 0; i < t_count; i++) apply_sgr_code(t_vals[i], r);
        end
        "s": begin
          r.action = aei_pkg::ActSave;
          t_saved_row = b.cur_row;
          t_saved_col = b.cur_col;
        end
        "u": begin
          r.action = aei_pkg::ActRestore;
          r.new_row = t_saved_row;
          r.new_col = t_saved_col;
        end
        "A": begin
          r.action = aei_pkg::ActUp;
          r.move_delta = 14'(delta);
          r.new_row = (b.cur_row > delta) ? 8'(b.cur_row - delta) : 8'd0;
        end
        "B": begin
          r.action = aei_pkg::ActDown;
          r.move_delta = 14'(delta);
          r.new_row = 8'(clamp_lim(b.cur_row + delta, t_rows));
        end
        "D": begin
          r.action = aei_pkg::ActLeft;
          r.move_delta = 14'(delta);
          r.new_col = (b.cur_col > delta) ? 8'(b.cur_col - delta) : 8'd0;
        end
        "C": begin
          r.action = aei_pkg::ActRight;
          r.move_delta = 14'(delta);
          r.new_col = 8'(clamp_lim(b.cur_col + delta, t_cols));
        end
        "H", "f": begin
          r.action = aei_pkg::ActAbs;
          tr = 0;
          tc = 0;
          if (t_count == 1) begin
            if (t_lead_semi) tc = a0;
            else tr = a0;
          end else if (t_count == 2) begin
            tr = a0;
            tc = a1;
          end
          tr = (tr > 0) ? tr - 1 : 0;
          tc = (tc > 0) ? tc - 1 : 0;
          r.new_row = 8'(clamp_lim(tr, t_scroll));
          r.new_col = 8'(clamp_lim(tc, t_cols));
        end
        default: r.action = aei_pkg::ActUnknown;
      endcase
    end else if (t_open) begin
      gather_char(c);
    end
    r.text_attr = t_attr;
    r.in_escape = t_open || t_after_esc || t_sound;
    return r;
  endfunction

  // stimulus helpers
  function automatic void push_char(logic [7:0] c);
    char_beat_t b;
    b.ch = c;
    b.cur_row = 8'($urandom_range(0, 254));
    b.cur_col = 8'($urandom_range(0, 254));
    if ($urandom_range(0, 9) == 0) b.cur_row = ($urandom_range(0, 1) != 0) ? 8'd254 : 8'd0;
    if ($urandom_range(0, 9) == 0) b.cur_col = ($urandom_range(0, 1) != 0) ? 8'd254 : 8'd0;
    char_q.push_back(b);
    action_q.push_back(interpret_char(b));
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) push_char(s[i]);
  endfunction

  function automatic string rand_number();
    case ($urandom_range(0, 5))
      0: return $sformatf("%0d", $urandom_range(0, 9));
      1: return $sformatf("%0d", $urandom_range(0, 99));
      2: return $sformatf("%0d", $urandom_range(30, 47));
      3: return $sformatf("%0d", $urandom_range(0, 7));
      4: return $sformatf("%0d", $urandom_range(0, 300));
      default: return $sformatf("%0d", $urandom_range(0, 99999));
    endcase
  endfunction

  function automatic void push_sequence();
    string      letters;
    string      s;
    int         n;
    logic [7:0] pb;
    letters = "mmmmABCDHfsuJKnMZq";
    s = "\033[";
    if ($urandom_range(0, 7) == 0) s = {s, ";"};
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      if (i > 0) s = {s, ($urandom_range(0, 9) == 0) ? ";;" : ";"};
      s = {s, rand_number()};
    end
    push_text(s);
    push_char(letters[$urandom_range(0, letters.len() - 1)]);
    // music payload and its end byte
    if (t_sound) begin
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        pb = 8'($urandom_range(1, 255));
        push_char((pb == aei_pkg::SoundEnd) ? 8'd15 : pb);
      end
      push_char(aei_pkg::SoundEnd);
    end
  endfunction

  function automatic void push_noise();
    case ($urandom_range(0, 3))
      0: push_char(8'($urandom_range(0, 255)));
      1: begin
        push_char(aei_pkg::EscByte);
        push_char(8'($urandom_range(0, 255)));
      end
      2: begin
        push_text("\033[");
        repeat ($urandom_range(0, 70)) push_char(8'($urandom_range(0, 255)));
      end
      default: push_char(aei_pkg::SoundEnd);
    endcase
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      aei_pkg::RegScreenRows: t_rows = val[7:0];
      aei_pkg::RegScreenCols: t_cols = val[7:0];
      aei_pkg::RegScrollRows: t_scroll = val[7:0];
      default:                t_cmap = val;
    endcase
  endtask

  task automatic drain();
    wait (action_q.size() == 0 && char_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) void'(char_q.pop_front());
      if ((s_axis_tvalid && !s_axis_tready) ||
          (char_q.size() > 0 && (idle_free || $urandom_range(0, 99) >= 10))) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= char_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    term_action_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= idle_free || $urandom_range(0, 99) >= 10;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (action_q.size() == 0) begin
          $error("unexpected output beat %h", m_axis_tdata);
          errors++;
        end else begin
          want = action_q.pop_front();
          if (got.action !== want.action) begin
            $error("action exp %0d got %0d", want.action, got.action); errors++; end
          if (got.new_row !== want.new_row) begin
            $error("new_row exp %0d got %0d", want.new_row, got.new_row); errors++; end
          if (got.new_col !== want.new_col) begin
            $error("new_col exp %0d got %0d", want.new_col, got.new_col); errors++; end
          if (got.text_attr !== want.text_attr) begin
            $error("text_attr exp %h got %h", want.text_attr, got.text_attr); errors++; end
          if (got.fore_set !== want.fore_set) begin
            $error("fore_set exp %0d got %0d", want.fore_set, got.fore_set); errors++; end
          if (got.fore_index !== want.fore_index) begin
            $error("fore_index exp %0d got %0d", want.fore_index, got.fore_index); errors++; end
          if (got.back_set !== want.back_set) begin
            $error("back_set exp %0d got %0d", want.back_set, got.back_set); errors++; end
          if (got.back_index !== want.back_index) begin
            $error("back_index exp %0d got %0d", want.back_index, got.back_index); errors++; end
          if (got.move_delta !== want.move_delta) begin
            $error("move_delta exp %0d got %0d", want.move_delta, got.move_delta); errors++; end
          if (got.in_escape !== want.in_escape) begin
            $error("in_escape exp %0d got %0d", want.in_escape, got.in_escape); errors++; end
          if (got.fill !== 5'd0) begin
            $error("fill exp 0 got %h", got.fill); errors++; end
        end
      end
    end
  end

  // stimulus
  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = aei_pkg::RegScreenRows;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    t_rows = 8'd24;
    t_cols = 8'd80;
    t_scroll = 8'd24;
    t_cmap = 24'hEE9CA0;
    t_open = 0; t_after_esc = 0; t_sound = 0;
    t_blink = 0; t_bold = 0;
    t_attr = 8'd7; t_saved_row = 0; t_saved_col = 0;
    drop_params();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every letter, saturation, leading separator, stray bytes
    push_text("x\033[1;5;4;31;42m\033[7m\033[0;37;47m");
    push_text("\033[99999A\033[B\033[0D\033[300C\033[;7H\033[3;9f\033[5H\033[1;2;3H");
    push_text("\033[s\033[u\033[J\033[K\033[6n\033[5n\033[Z\033(");
    push_char(8'd0);
    push_text("\033[M");
    push_char(8'd255);
    push_char(aei_pkg::SoundEnd);
    push_char(8'd128);
    drain();

    // sweep register settings, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin cfg_write(aei_pkg::RegScreenRows, 24'd0);
                 cfg_write(aei_pkg::RegScreenCols, 24'd0);
                 cfg_write(aei_pkg::RegScrollRows, 24'd0);
                 cfg_write(aei_pkg::RegColorMap, 24'd0); end
        1: begin cfg_write(aei_pkg::RegScreenRows, 24'd255);
                 cfg_write(aei_pkg::RegScreenCols, 24'd255);
                 cfg_write(aei_pkg::RegScrollRows, 24'd255);
                 cfg_write(aei_pkg::RegColorMap, 24'hFFFFFF); end
        2: begin cfg_write(aei_pkg::RegScreenRows, 24'd1);
                 cfg_write(aei_pkg::RegScreenCols, 24'd1);
                 cfg_write(aei_pkg::RegScrollRows, 24'd1);
                 cfg_write(aei_pkg::RegColorMap, 24'hFAC688); end
        default: begin
          cfg_write(aei_pkg::RegScreenRows, 24'($urandom_range(0, 255)));
          cfg_write(aei_pkg::RegScreenCols, 24'($urandom_range(0, 255)));
          cfg_write(aei_pkg::RegScrollRows, 24'($urandom_range(0, 255)));
          cfg_write(aei_pkg::RegColorMap, 24'($urandom_range(0, 24'hFFFFFF)));
        end
      endcase
      idle_free = (phase == 4);
      while (action_q.size() < 300) begin
        if ($urandom_range(0, 9) < 8) push_sequence();
        else push_noise();
      end
      drain();
    end
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/aei_pkg.sv
src/aei_datapath.sv
src/aei_ctrl.sv
src/ansi_escape_interpreter_unit.sv
src/aei_checker.sv
sim/tb.sv
